### design/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit.
// Used by rau_front, rau_back, rau_reduce and the top level.
`default_nettype none
package rau_pkg;

    // Commands as they arrive on cmd
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4
    } op_t;

    // How the front end classified an item
    typedef enum logic [1:0] {
        K_OP   = 2'd0,
        K_NONE = 2'd1,
        K_DBZ  = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DBZ = 2'd1,
        ST_OVF = 2'd2
    } st_t;

    // Control word handed from front end to back end
    typedef struct packed {
        op_t   op;
        kind_t kind;
    } ctl_t;

    // Reducer sequencer
    typedef enum logic [1:0] {
        R_IDLE,
        R_GCD,
        R_DIV,
        R_DONE
    } red_state_t;

    // Back end sequencer
    typedef enum logic [3:0] {
        B_IDLE,
        B_RA,
        B_RA_W,
        B_RB,
        B_RB_W,
        B_M0,
        B_M1,
        B_M2,
        B_SUM,
        B_RR,
        B_RR_W,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

### design/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares
// two fractions and returns the result in lowest terms with a positive
// denominator. A front end takes an item per cycle into a two-entry queue while
// the queue is not full; the back end works on one item at a time. An item
// takes three reductions (a compare two), each a binary GCD of one step a
// cycle followed by a bit-serial division. The shared reducer sets the time
// an item takes. Zero denominators, zero divisors and unused commands skip
// the reductions.
// Depends on rau_pkg, rau_front, rau_fifo, rau_back, rau_reduce.
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [31:0] b_den,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      res_num,
    output logic [30:0]      res_den,
    output logic             equal,
    output logic [1:0]       status
);

    localparam int W  = WORD_BITS;
    localparam int DW = $bits(ctl_t) + 2 + 4 * W;

    ctl_t          f_ctl, b_ctl;
    logic          f_aneg, f_bneg, b_aneg, b_bneg;
    logic [W-1:0]  f_an, f_ad, f_bn, f_bd;
    logic [W-1:0]  b_an, b_ad, b_bn, b_bd;
    logic [DW-1:0] q_wdata, q_rdata;
    logic          q_full, q_empty, q_pop, q_push;

    rau_front #(
        .W(W)
    ) u_front (
        .cmd    (cmd),
        .a_num  (a_num),
        .a_den  (a_den),
        .b_num  (b_num),
        .b_den  (b_den),
        .ctl    (f_ctl),
        .a_neg  (f_aneg),
        .b_neg  (f_bneg),
        .an_mag (f_an),
        .ad_mag (f_ad),
        .bn_mag (f_bn),
        .bd_mag (f_bd)
    );

    // Queue between front and back
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_wdata  = {f_ctl, f_aneg, f_bneg, f_an, f_ad, f_bn, f_bd};
    assign {b_ctl, b_aneg, b_bneg, b_an, b_ad, b_bn, b_bd} = q_rdata;

    rau_fifo #(
        .DW(DW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    rau_back #(
        .W(W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .ctl       (b_ctl),
        .a_neg_in  (b_aneg),
        .b_neg_in  (b_bneg),
        .an_in     (b_an),
        .ad_in     (b_ad),
        .bn_in     (b_bn),
        .bd_in     (b_bd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den),
        .equal     (equal),
        .status    (status)
    );

endmodule
`default_nettype wire

### design/rau_front.sv
// rau_front: splits the two's complement operand words into sign and magnitude
// and classifies the item. Depends on rau_pkg. Feeds rau_fifo.
`default_nettype none
module rau_front
    import rau_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [31:0] b_den,
    output ctl_t             ctl,
    output logic             a_neg,
    output logic             b_neg,
    output logic [W-1:0]     an_mag,
    output logic [W-1:0]     ad_mag,
    output logic [W-1:0]     bn_mag,
    output logic [W-1:0]     bd_mag
);

    logic [W-1:0] an_w, ad_w, bn_w, bd_w;

    assign an_w = a_num[W-1:0];
    assign ad_w = a_den[W-1:0];
    assign bn_w = b_num[W-1:0];
    assign bd_w = b_den[W-1:0];

    // Magnitudes of the low word; the most negative word maps to 2^(W-1)
    assign an_mag = an_w[W-1] ? (~an_w + W'(1)) : an_w;
    assign ad_mag = ad_w[W-1] ? (~ad_w + W'(1)) : ad_w;
    assign bn_mag = bn_w[W-1] ? (~bn_w + W'(1)) : bn_w;
    assign bd_mag = bd_w[W-1] ? (~bd_w + W'(1)) : bd_w;

    // Sign of each fraction before reduction
    assign a_neg = an_w[W-1] ^ ad_w[W-1];
    assign b_neg = bn_w[W-1] ^ bd_w[W-1];

    // Classification: unused command, zero denominator, zero divisor
    always_comb
    begin
        ctl.op = op_t'(cmd);
        priority if (cmd > OP_EQ)
        begin
            ctl.kind = K_NONE;
        end
        else if (ad_w == '0 || bd_w == '0)
        begin
            ctl.kind = K_DBZ;
        end
        else if (cmd == OP_DIV && bn_w == '0)
        begin
            ctl.kind = K_DBZ;
        end
        else
        begin
            ctl.kind = K_OP;
        end
    end

endmodule
`default_nettype wire

### design/rau_fifo.sv
// rau_fifo: two-entry queue between the front end and the back end.
// Generic data vector; no package dependency.
`default_nettype none
module rau_fifo #(
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          pop,
    output logic [DW-1:0]      rdata,
    output logic               full,
    output logic               empty
);

    logic [DW-1:0] mem_reg [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    // Pointer and count update
    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### design/rau_reduce.sv
// rau_reduce: puts x/y in lowest terms. Binary GCD one step a cycle, then
// two bit-serial exact divisions by the GCD in parallel. Depends on rau_pkg.
`default_nettype none
module rau_reduce
    import rau_pkg::*;
#(
    parameter int PW = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [PW-1:0] x,
    input  wire logic [PW-1:0] y,
    output logic               done,
    output logic [PW-1:0]      qx,
    output logic [PW-1:0]      qy
);

    localparam int KW = $clog2(PW + 1);

    red_state_t    state_reg, state_next;
    logic [PW-1:0] u_reg, u_next;
    logic [PW-1:0] v_reg, v_next;
    logic [KW-1:0] k_reg, k_next;
    logic [PW-1:0] g_reg, g_next;
    logic [PW-1:0] x_reg, x_next;
    logic [PW-1:0] y_reg, y_next;
    logic [PW-1:0] rx_reg, rx_next;
    logic [PW-1:0] ry_reg, ry_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [PW:0]   rxs, rys;

    assign done = state_reg == R_DONE;
    assign qx   = x_reg;
    assign qy   = y_reg;
    assign rxs  = {rx_reg, x_reg[PW-1]};
    assign rys  = {ry_reg, y_reg[PW-1]};

    // Sequencer: gcd steps, then PW division steps
    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    u_next     = x;
                    v_next     = y;
                    x_next     = x;
                    y_next     = y;
                    k_next     = '0;
                    state_next = R_GCD;
                end
            end
            R_GCD:
            begin
                priority if (u_reg == '0)
                begin
                    g_next     = v_reg << k_reg;
                    rx_next    = '0;
                    ry_next    = '0;
                    cnt_next   = '0;
                    state_next = R_DIV;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg >= v_reg)
                begin
                    u_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end
            R_DIV:
            begin
                // Restoring division, quotient shifts into the dividend reg
                if (rxs >= {1'b0, g_reg})
                begin
                    rx_next = PW'(rxs - {1'b0, g_reg});
                    x_next  = {x_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rx_next = rxs[PW-1:0];
                    x_next  = {x_reg[PW-2:0], 1'b0};
                end
                if (rys >= {1'b0, g_reg})
                begin
                    ry_next = PW'(rys - {1'b0, g_reg});
                    y_next  = {y_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    ry_next = rys[PW-1:0];
                    y_next  = {y_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == KW'(PW - 1))
                begin
                    state_next = R_DONE;
                end
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        cnt_reg <= cnt_next;
    end

endmodule
`default_nettype wire

### design/rau_back.sv
// rau_back: carries out one queued item: reduces both inputs, forms the cross
// products, reduces the result and holds it in the output register. A compare
// ends after the input reductions. Depends on rau_pkg and rau_reduce.
`default_nettype none
module rau_back
    import rau_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_empty,
    output logic              q_pop,
    input  ctl_t              ctl,
    input  wire logic         a_neg_in,
    input  wire logic         b_neg_in,
    input  wire logic [W-1:0] an_in,
    input  wire logic [W-1:0] ad_in,
    input  wire logic [W-1:0] bn_in,
    input  wire logic [W-1:0] bd_in,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       res_num,
    output logic [30:0]       res_den,
    output logic              equal,
    output logic [1:0]        status
);

    localparam int PW = 2 * W;
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);
    localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

    back_state_t   state_reg, state_next;
    op_t           op_reg, op_next;
    logic          an_neg_reg, an_neg_next;
    logic          bn_neg_reg, bn_neg_next;
    logic [W-1:0]  an_reg, an_next, ad_reg, ad_next;
    logic [W-1:0]  bn_reg, bn_next, bd_reg, bd_next;
    logic [PW-1:0] t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic          neg_reg, neg_next;
    logic [31:0]   rnum_reg, rnum_next;
    logic [30:0]   rden_reg, rden_next;
    logic          req_reg, req_next;
    st_t           rst_reg, rst_next;
    logic          ov_reg, ov_next;
    logic [31:0]   onum_reg, onum_next;
    logic [30:0]   oden_reg, oden_next;
    logic          oeq_reg, oeq_next;
    st_t           ost_reg, ost_next;

    logic          red_start, red_done;
    logic [PW-1:0] red_x, red_y, red_qx, red_qy;
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic          t2_neg, red_neg, ovf;
    logic [31:0]   mag32;

    assign out_valid = ov_reg;
    assign res_num   = onum_reg;
    assign res_den   = oden_reg;
    assign equal     = oeq_reg;
    assign status    = ost_reg;

    rau_reduce #(
        .PW(PW)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .x     (red_x),
        .y     (red_y),
        .done  (red_done),
        .qx    (red_qx),
        .qy    (red_qy)
    );

    // Shared multiplier, operands picked by step and command
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        unique case (state_reg)
            B_M0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            B_M1:
            begin
                mul_a = (op_reg == OP_MUL) ? ad_reg : bn_reg;
                mul_b = (op_reg == OP_MUL) ? bd_reg : ad_reg;
            end
            B_M2:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Reducer operands
    always_comb
    begin
        unique case (state_reg)
            B_RA:    begin red_x = PW'(an_reg); red_y = PW'(ad_reg); end
            B_RB:    begin red_x = PW'(bn_reg); red_y = PW'(bd_reg); end
            default: begin red_x = t1_reg;      red_y = t2_reg;      end
        endcase
    end
    assign red_start = state_reg == B_RA || state_reg == B_RB || state_reg == B_RR;

    // Result checks
    assign t2_neg  = (t2_reg != '0) && ((op_reg == OP_SUB) ? !bn_neg_reg : bn_neg_reg);
    assign red_neg = neg_reg && (red_qx != '0);
    assign ovf     = (red_neg ? (red_qx > LIM_NEG) : (red_qx > LIM_POS)) ||
                     (red_qy > LIM_POS);
    assign mag32   = 32'(red_qx[W-1:0]);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        an_neg_next = an_neg_reg;
        bn_neg_next = bn_neg_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        t3_next     = t3_reg;
        neg_next    = neg_reg;
        rnum_next   = rnum_reg;
        rden_next   = rden_reg;
        req_next    = req_reg;
        rst_next    = rst_reg;
        ov_next     = ov_reg && !out_ready;
        onum_next   = onum_reg;
        oden_next   = oden_reg;
        oeq_next    = oeq_reg;
        ost_next    = ost_reg;
        q_pop       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    op_next     = ctl.op;
                    an_neg_next = a_neg_in;
                    bn_neg_next = b_neg_in;
                    an_next     = an_in;
                    ad_next     = ad_in;
                    bn_next     = bn_in;
                    bd_next     = bd_in;
                    rnum_next   = '0;
                    rden_next   = '0;
                    req_next    = 1'b0;
                    unique case (ctl.kind)
                        K_OP:    begin rst_next = ST_OK;  state_next = B_RA;   end
                        K_DBZ:   begin rst_next = ST_DBZ; state_next = B_DONE; end
                        default: begin rst_next = ST_OK;  state_next = B_DONE; end
                    endcase
                end
            end
            B_RA: state_next = B_RA_W;
            B_RA_W:
            begin
                if (red_done)
                begin
                    an_next     = red_qx[W-1:0];
                    ad_next     = red_qy[W-1:0];
                    an_neg_next = an_neg_reg && (red_qx != '0);
                    state_next  = B_RB;
                end
            end
            B_RB: state_next = B_RB_W;
            B_RB_W:
            begin
                if (red_done)
                begin
                    bn_next     = red_qx[W-1:0];
                    bd_next     = red_qy[W-1:0];
                    bn_neg_next = bn_neg_reg && (red_qx != '0);
                    state_next  = B_M0;
                end
            end
            B_M0:
            begin
                if (op_reg == OP_EQ)
                begin
                    req_next   = (an_neg_reg == bn_neg_reg) && (an_reg == bn_reg) &&
                                 (ad_reg == bd_reg);
                    state_next = B_DONE;
                end
                else
                begin
                    t1_next    = mul_p;
                    neg_next   = an_neg_reg ^ bn_neg_reg;
                    state_next = B_M1;
                end
            end
            B_M1:
            begin
                t2_next    = mul_p;
                state_next = (op_reg == OP_ADD || op_reg == OP_SUB) ? B_M2 : B_RR;
            end
            B_M2:
            begin
                t3_next    = mul_p;
                state_next = B_SUM;
            end
            B_SUM:
            begin
                // Sign-magnitude add of a.n*b.d and (+/-)b.n*a.d
                priority if (an_neg_reg == t2_neg)
                begin
                    t1_next  = t1_reg + t2_reg;
                    neg_next = an_neg_reg;
                end
                else if (t1_reg >= t2_reg)
                begin
                    t1_next  = t1_reg - t2_reg;
                    neg_next = an_neg_reg;
                end
                else
                begin
                    t1_next  = t2_reg - t1_reg;
                    neg_next = t2_neg;
                end
                t2_next    = t3_reg;
                state_next = B_RR;
            end
            B_RR: state_next = B_RR_W;
            B_RR_W:
            begin
                if (red_done)
                begin
                    if (ovf)
                    begin
                        rst_next = ST_OVF;
                    end
                    else
                    begin
                        rnum_next = red_neg ? (~mag32 + 32'd1) : mag32;
                        rden_next = 31'(red_qy[W-1:0]);
                    end
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    onum_next  = rnum_reg;
                    oden_next  = rden_reg;
                    oeq_next   = req_reg;
                    ost_next   = rst_reg;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        an_neg_reg <= an_neg_next;
        bn_neg_reg <= bn_neg_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        neg_reg    <= neg_next;
        rnum_reg   <= rnum_next;
        rden_reg   <= rden_next;
        req_reg    <= req_next;
        rst_reg    <= rst_next;
        onum_reg   <= onum_next;
        oden_reg   <= oden_next;
        oeq_reg    <= oeq_next;
        ost_reg    <= ost_next;
    end

endmodule
`default_nettype wire
